/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/bpa_pkg.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes, controller states, datapath operations and shared helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_PAGES  = 16384;
    localparam int NUM_ORDERS = 11;
    localparam int TOP_ORD    = NUM_ORDERS - 1;
    localparam int BLK_PAGES  = 1 << TOP_ORD;

    localparam int IDX_W    = $clog2(NUM_PAGES);
    localparam int PG_W     = $clog2(NUM_PAGES + 1);
    localparam int SUM_W    = PG_W + 1;
    localparam int CNT_W    = 15;
    localparam int CFG_W    = 15;
    localparam int PAGE_W   = 14;
    localparam int ORDER_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [PG_W-1:0]  EMPTY_LINK = PG_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOBLK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [4:0] {
        S_CLR_START,
        S_CLR,
        S_RB_INIT,
        S_RB,
        S_IDLE,
        S_DISPATCH,
        S_A_SCAN,
        S_A_POP_RD,
        S_A_POP_WR,
        S_A_PUSH_LO,
        S_A_PUSH_HI,
        S_A_GRANT,
        S_F_LOOP,
        S_F_BUD,
        S_F_WALK,
        S_F_WALK2,
        S_F_UNL2,
        S_F_MERGE1,
        S_F_MERGE2,
        S_F_PUSH,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_START,
        OP_CLR,
        OP_RB_INIT,
        OP_RB_DEC,
        OP_RB_PUSH,
        OP_LOAD,
        OP_SCAN_INC,
        OP_POP_RD,
        OP_POP_WR,
        OP_PUSH_LO,
        OP_PUSH_HI,
        OP_GRANT,
        OP_BUD_RD,
        OP_WALK_INIT,
        OP_WALK_RD,
        OP_WALK_NEXT,
        OP_UNLINK,
        OP_UNLINK2,
        OP_MERGE1,
        OP_MERGE2,
        OP_FPUSH,
        OP_ERR_RANGE,
        OP_ERR_NOBLK,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   cfg_we;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic rb_empty;
        logic rb_done;
        logic rb_dec;
        logic cmd_free;
        logic ord_bad;
        logic free_bad;
        logic scan_end;
        logic head_empty;
        logic split_more;
        logic lp_top;
        logic bud_past;
        logic bud_ok;
        logic walk_end;
        logic hit;
    } dp_stat_t;

    function automatic logic [PG_W-1:0] clamp_link(input logic [PG_W-1:0] x);
        return (x < PG_W'(NUM_PAGES)) ? x : EMPTY_LINK;
    endfunction

endpackage

/* hdl/bpa_ifs.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator channels
// Valid/ready channels for requests, responses and the configuration write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [bpa_pkg::ORDER_W-1:0] block_order;
    logic [bpa_pkg::PAGE_W-1:0]  page_number;

    modport source (output valid, cmd, block_order, page_number, input ready);
    modport sink   (input valid, cmd, block_order, page_number, output ready);
endinterface

interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::STATUS_W-1:0] status;
    logic [bpa_pkg::PAGE_W-1:0]   granted_page;

    modport source (output valid, status, granted_page, input ready);
    modport sink   (input valid, status, granted_page, output ready);
endinterface

interface bpa_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bpa_pkg::CFG_W-1:0] first_free_page;

    modport source (output valid, first_free_page, input ready);
    modport sink   (input valid, first_free_page, output ready);
endinterface

/* hdl/bpa_ctrl.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences clearing, pool rebuild, allocation and free through the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::dp_cmd_t  cmd
);

    bpa_pkg::ctrl_state_t state_reg;
    bpa_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 publish;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign publish   = (cmd.op == bpa_pkg::OP_PUBLISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_CLR_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpa_pkg::OP_NONE;
        cmd.cfg_we = cfg_valid;
        in_ready   = 1'b0;
        case (state_reg)
            bpa_pkg::S_CLR_START:
            begin
                cmd.op     = bpa_pkg::OP_CLR_START;
                state_next = bpa_pkg::S_CLR;
            end
            bpa_pkg::S_CLR:
            begin
                cmd.op = bpa_pkg::OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = bpa_pkg::S_RB_INIT;
                end
            end
            bpa_pkg::S_RB_INIT:
            begin
                if (stat.rb_empty)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_RB_INIT;
                    state_next = bpa_pkg::S_RB;
                end
            end
            bpa_pkg::S_RB:
            begin
                if (stat.rb_done)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
                else if (stat.rb_dec)
                begin
                    cmd.op = bpa_pkg::OP_RB_DEC;
                end
                else
                begin
                    cmd.op = bpa_pkg::OP_RB_PUSH;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                in_ready = !cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    cmd.op     = bpa_pkg::OP_LOAD;
                    state_next = bpa_pkg::S_DISPATCH;
                end
            end
            bpa_pkg::S_DISPATCH:
            begin
                if (stat.cmd_free ? stat.free_bad : stat.ord_bad)
                begin
                    cmd.op     = bpa_pkg::OP_ERR_RANGE;
                    state_next = bpa_pkg::S_DONE;
                end
                else if (stat.cmd_free)
                begin
                    state_next = bpa_pkg::S_F_LOOP;
                end
                else
                begin
                    state_next = bpa_pkg::S_A_SCAN;
                end
            end
            bpa_pkg::S_A_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = bpa_pkg::OP_ERR_NOBLK;
                    state_next = bpa_pkg::S_DONE;
                end
                else if (stat.head_empty)
                begin
                    cmd.op = bpa_pkg::OP_SCAN_INC;
                end
                else
                begin
                    state_next = bpa_pkg::S_A_POP_RD;
                end
            end
            bpa_pkg::S_A_POP_RD:
            begin
                cmd.op     = bpa_pkg::OP_POP_RD;
                state_next = bpa_pkg::S_A_POP_WR;
            end
            bpa_pkg::S_A_POP_WR:
            begin
                cmd.op     = bpa_pkg::OP_POP_WR;
                state_next = stat.split_more ? bpa_pkg::S_A_PUSH_LO : bpa_pkg::S_A_GRANT;
            end
            bpa_pkg::S_A_PUSH_LO:
            begin
                cmd.op     = bpa_pkg::OP_PUSH_LO;
                state_next = bpa_pkg::S_A_PUSH_HI;
            end
            bpa_pkg::S_A_PUSH_HI:
            begin
                cmd.op     = bpa_pkg::OP_PUSH_HI;
                state_next = bpa_pkg::S_A_POP_RD;
            end
            bpa_pkg::S_A_GRANT:
            begin
                cmd.op     = bpa_pkg::OP_GRANT;
                state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_F_LOOP:
            begin
                if (stat.lp_top || stat.bud_past)
                begin
                    state_next = bpa_pkg::S_F_PUSH;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_BUD_RD;
                    state_next = bpa_pkg::S_F_BUD;
                end
            end
            bpa_pkg::S_F_BUD:
            begin
                if (stat.bud_ok)
                begin
                    cmd.op     = bpa_pkg::OP_WALK_INIT;
                    state_next = bpa_pkg::S_F_WALK;
                end
                else
                begin
                    state_next = bpa_pkg::S_F_PUSH;
                end
            end
            bpa_pkg::S_F_WALK:
            begin
                if (stat.walk_end)
                begin
                    state_next = bpa_pkg::S_F_MERGE1;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_WALK_RD;
                    state_next = bpa_pkg::S_F_WALK2;
                end
            end
            bpa_pkg::S_F_WALK2:
            begin
                if (stat.hit)
                begin
                    cmd.op     = bpa_pkg::OP_UNLINK;
                    state_next = bpa_pkg::S_F_UNL2;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_WALK_NEXT;
                    state_next = bpa_pkg::S_F_WALK;
                end
            end
            bpa_pkg::S_F_UNL2:
            begin
                cmd.op     = bpa_pkg::OP_UNLINK2;
                state_next = bpa_pkg::S_F_MERGE1;
            end
            bpa_pkg::S_F_MERGE1:
            begin
                cmd.op     = bpa_pkg::OP_MERGE1;
                state_next = bpa_pkg::S_F_MERGE2;
            end
            bpa_pkg::S_F_MERGE2:
            begin
                cmd.op     = bpa_pkg::OP_MERGE2;
                state_next = bpa_pkg::S_F_LOOP;
            end
            bpa_pkg::S_F_PUSH:
            begin
                cmd.op     = bpa_pkg::OP_FPUSH;
                state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE:
            begin
                // The result slot must be empty or emptying this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = bpa_pkg::OP_PUBLISH;
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_CLR_START;
            end
        endcase
        if (cfg_valid)
        begin
            state_next = bpa_pkg::S_CLR_START;
        end
    end

endmodule

/* hdl/bpa_dp.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator datapath
// Page memories, free list heads and counts, and the working registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::dp_cmd_t              cmd,
    input  logic [bpa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_cmd,
    input  logic [bpa_pkg::ORDER_W-1:0]   in_order,
    input  logic [bpa_pkg::PAGE_W-1:0]    in_page,
    output bpa_pkg::dp_stat_t             stat,
    output logic [bpa_pkg::STATUS_W-1:0]  res_status,
    output logic [bpa_pkg::PAGE_W-1:0]    res_page
);

    localparam int N      = bpa_pkg::NUM_PAGES;
    localparam int IDX_W  = bpa_pkg::IDX_W;
    localparam int PG_W   = bpa_pkg::PG_W;
    localparam int SUM_W  = bpa_pkg::SUM_W;
    localparam int ORD_W  = bpa_pkg::ORDER_W;
    localparam int CNT_W  = bpa_pkg::CNT_W;

    logic [bpa_pkg::CFG_W-1:0]    ffp_reg;
    logic [PG_W-1:0]              head_reg [bpa_pkg::NUM_ORDERS];
    logic [CNT_W-1:0]             cnt_reg  [bpa_pkg::NUM_ORDERS];

    logic                         cmd_reg;
    logic [ORD_W-1:0]             o_reg;
    logic [ORD_W-1:0]             i_reg;
    logic [PG_W-1:0]              pg_reg;
    logic [PG_W-1:0]              left_reg;
    logic [PG_W-1:0]              p_reg;
    logic [IDX_W-1:0]             bud_reg;
    logic [PG_W-1:0]              t_reg;
    logic [PG_W-1:0]              prev_reg;
    logic [PG_W-1:0]              steps_reg;
    logic [IDX_W-1:0]             clr_reg;
    logic [bpa_pkg::STATUS_W-1:0] st_reg;
    logic [bpa_pkg::PAGE_W-1:0]   gp_reg;
    logic [bpa_pkg::STATUS_W-1:0] out_st_reg;
    logic [bpa_pkg::PAGE_W-1:0]   out_gp_reg;

    logic                         fr_mem [N];
    logic [ORD_W-1:0]             or_mem [N];
    logic [PG_W-1:0]              nl_mem [N];
    logic                         fr_q;
    logic [ORD_W-1:0]             or_q;
    logic [PG_W-1:0]              nl_q;

    logic                         fr_we;
    logic [IDX_W-1:0]             fr_waddr;
    logic                         fr_wd;
    logic                         or_we;
    logic [IDX_W-1:0]             or_waddr;
    logic [ORD_W-1:0]             or_wd;
    logic                         nl_we;
    logic [IDX_W-1:0]             nl_waddr;
    logic [PG_W-1:0]              nl_wd;
    logic [IDX_W-1:0]             nl_raddr;

    logic                         push_en;
    logic [ORD_W-1:0]             push_ord;
    logic [IDX_W-1:0]             push_pg;

    logic [SUM_W-1:0]             sz;
    logic [SUM_W-1:0]             rb_sum;
    logic [SUM_W-1:0]             rb_start;
    logic [IDX_W-1:0]             bud_c;
    logic [SUM_W-1:0]             up_sum;
    logic [SUM_W-1:0]             up_mod;
    logic [IDX_W-1:0]             up_pg;
    logic [PG_W-1:0]              nl_clamped;

    assign sz         = SUM_W'(1) << i_reg;
    assign rb_sum     = SUM_W'(ffp_reg) + SUM_W'(bpa_pkg::BLK_PAGES - 1);
    assign rb_start   = rb_sum & ~SUM_W'(bpa_pkg::BLK_PAGES - 1);
    assign bud_c      = pg_reg[IDX_W-1:0] ^ sz[IDX_W-1:0];
    assign up_sum     = SUM_W'(p_reg) + sz;
    assign up_mod     = (up_sum >= SUM_W'(N)) ? (up_sum - SUM_W'(N)) : up_sum;
    assign up_pg      = up_mod[IDX_W-1:0];
    assign nl_clamped = bpa_pkg::clamp_link(nl_q);

    always_comb
    begin
        stat.clr_last   = (clr_reg == IDX_W'(N - 1));
        stat.rb_empty   = (rb_start >= SUM_W'(N));
        stat.rb_done    = (left_reg == '0);
        stat.rb_dec     = (i_reg != '0) && (SUM_W'(left_reg) < sz);
        stat.cmd_free   = (cmd_reg == bpa_pkg::CMD_FREE);
        stat.ord_bad    = (o_reg >= ORD_W'(bpa_pkg::NUM_ORDERS));
        stat.free_bad   = stat.ord_bad || (pg_reg >= PG_W'(N))
                          || ((SUM_W'(pg_reg) & (sz - SUM_W'(1))) != '0)
                          || ((SUM_W'(pg_reg) + sz) > SUM_W'(N));
        stat.scan_end   = (i_reg >= ORD_W'(bpa_pkg::NUM_ORDERS));
        stat.head_empty = (head_reg[i_reg] == bpa_pkg::EMPTY_LINK);
        stat.split_more = (i_reg > o_reg);
        stat.lp_top     = (i_reg >= ORD_W'(bpa_pkg::TOP_ORD));
        stat.bud_past   = ((SUM_W'(bud_c) + sz) > SUM_W'(N));
        stat.bud_ok     = fr_q && (or_q == i_reg);
        stat.walk_end   = (t_reg == bpa_pkg::EMPTY_LINK) || (steps_reg >= PG_W'(N));
        stat.hit        = (t_reg == PG_W'(bud_reg));
    end

    // Memory port steering. A push writes all three page stores at once.
    always_comb
    begin
        fr_we    = 1'b0;
        fr_waddr = pg_reg[IDX_W-1:0];
        fr_wd    = 1'b0;
        or_we    = 1'b0;
        or_waddr = pg_reg[IDX_W-1:0];
        or_wd    = '0;
        nl_we    = 1'b0;
        nl_waddr = t_reg[IDX_W-1:0];
        nl_wd    = bpa_pkg::EMPTY_LINK;
        nl_raddr = t_reg[IDX_W-1:0];
        push_en  = 1'b0;
        push_ord = i_reg;
        push_pg  = pg_reg[IDX_W-1:0];
        case (cmd.op)
            bpa_pkg::OP_CLR:
            begin
                fr_we    = 1'b1;
                fr_waddr = clr_reg;
                or_we    = 1'b1;
                or_waddr = clr_reg;
            end
            bpa_pkg::OP_RB_PUSH, bpa_pkg::OP_FPUSH:
            begin
                push_en = 1'b1;
            end
            bpa_pkg::OP_PUSH_LO:
            begin
                push_en  = 1'b1;
                push_ord = i_reg - ORD_W'(1);
                push_pg  = p_reg[IDX_W-1:0];
            end
            bpa_pkg::OP_PUSH_HI:
            begin
                push_en = 1'b1;
                push_pg = up_pg;
            end
            bpa_pkg::OP_POP_RD:
            begin
                nl_raddr = head_reg[i_reg][IDX_W-1:0];
            end
            bpa_pkg::OP_GRANT:
            begin
                fr_we    = 1'b1;
                fr_waddr = p_reg[IDX_W-1:0];
                nl_we    = 1'b1;
                nl_waddr = p_reg[IDX_W-1:0];
            end
            bpa_pkg::OP_UNLINK:
            begin
                nl_we    = (prev_reg != bpa_pkg::EMPTY_LINK);
                nl_waddr = prev_reg[IDX_W-1:0];
                nl_wd    = nl_clamped;
            end
            bpa_pkg::OP_UNLINK2:
            begin
                nl_we = 1'b1;
            end
            bpa_pkg::OP_MERGE1:
            begin
                fr_we    = 1'b1;
                fr_waddr = bud_reg;
            end
            bpa_pkg::OP_MERGE2:
            begin
                fr_we = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (push_en)
        begin
            fr_we    = 1'b1;
            fr_waddr = push_pg;
            fr_wd    = 1'b1;
            or_we    = 1'b1;
            or_waddr = push_pg;
            or_wd    = push_ord;
            nl_we    = 1'b1;
            nl_waddr = push_pg;
            nl_wd    = head_reg[push_ord];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            fr_mem[fr_waddr] <= fr_wd;
        end
        fr_q <= fr_mem[bud_c];
    end

    always_ff @(posedge clk)
    begin
        if (or_we)
        begin
            or_mem[or_waddr] <= or_wd;
        end
        or_q <= or_mem[bud_c];
    end

    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            nl_mem[nl_waddr] <= nl_wd;
        end
        nl_q <= nl_mem[nl_raddr];
    end

    // List heads, counts and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ffp_reg <= '0;
            for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++)
            begin
                head_reg[k] <= bpa_pkg::EMPTY_LINK;
                cnt_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                ffp_reg <= cfg_data;
            end
            if (push_en)
            begin
                head_reg[push_ord] <= PG_W'(push_pg);
                if (cnt_reg[push_ord] != bpa_pkg::COUNT_MAX)
                begin
                    cnt_reg[push_ord] <= cnt_reg[push_ord] + CNT_W'(1);
                end
            end
            case (cmd.op)
                bpa_pkg::OP_CLR_START:
                begin
                    for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++)
                    begin
                        head_reg[k] <= bpa_pkg::EMPTY_LINK;
                        cnt_reg[k]  <= '0;
                    end
                end
                bpa_pkg::OP_POP_WR:
                begin
                    head_reg[i_reg] <= nl_clamped;
                    if (cnt_reg[i_reg] != '0)
                    begin
                        cnt_reg[i_reg] <= cnt_reg[i_reg] - CNT_W'(1);
                    end
                end
                bpa_pkg::OP_UNLINK:
                begin
                    if (prev_reg == bpa_pkg::EMPTY_LINK)
                    begin
                        head_reg[i_reg] <= nl_clamped;
                    end
                end
                bpa_pkg::OP_UNLINK2:
                begin
                    if (cnt_reg[i_reg] != '0)
                    begin
                        cnt_reg[i_reg] <= cnt_reg[i_reg] - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_CLR_START:
            begin
                clr_reg <= '0;
            end
            bpa_pkg::OP_CLR:
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            bpa_pkg::OP_RB_INIT:
            begin
                pg_reg   <= PG_W'(rb_start);
                left_reg <= PG_W'(SUM_W'(N) - rb_start);
                i_reg    <= ORD_W'(bpa_pkg::TOP_ORD);
            end
            bpa_pkg::OP_RB_DEC:
            begin
                i_reg <= i_reg - ORD_W'(1);
            end
            bpa_pkg::OP_RB_PUSH:
            begin
                left_reg <= left_reg - PG_W'(sz);
                pg_reg   <= pg_reg + PG_W'(sz);
            end
            bpa_pkg::OP_LOAD:
            begin
                cmd_reg <= in_cmd;
                o_reg   <= in_order;
                i_reg   <= in_order;
                pg_reg  <= PG_W'(in_page);
            end
            bpa_pkg::OP_SCAN_INC:
            begin
                i_reg <= i_reg + ORD_W'(1);
            end
            bpa_pkg::OP_POP_RD:
            begin
                p_reg <= head_reg[i_reg];
            end
            bpa_pkg::OP_PUSH_LO:
            begin
                i_reg <= i_reg - ORD_W'(1);
            end
            bpa_pkg::OP_GRANT:
            begin
                st_reg <= bpa_pkg::ST_OK;
                gp_reg <= p_reg[bpa_pkg::PAGE_W-1:0];
            end
            bpa_pkg::OP_BUD_RD:
            begin
                bud_reg <= bud_c;
            end
            bpa_pkg::OP_WALK_INIT:
            begin
                prev_reg  <= bpa_pkg::EMPTY_LINK;
                t_reg     <= head_reg[i_reg];
                steps_reg <= '0;
            end
            bpa_pkg::OP_WALK_NEXT:
            begin
                prev_reg  <= t_reg;
                t_reg     <= nl_clamped;
                steps_reg <= steps_reg + PG_W'(1);
            end
            bpa_pkg::OP_MERGE2:
            begin
                if (PG_W'(bud_reg) < pg_reg)
                begin
                    pg_reg <= PG_W'(bud_reg);
                end
                i_reg <= i_reg + ORD_W'(1);
            end
            bpa_pkg::OP_FPUSH:
            begin
                st_reg <= bpa_pkg::ST_OK;
                gp_reg <= '0;
            end
            bpa_pkg::OP_ERR_RANGE:
            begin
                st_reg <= bpa_pkg::ST_RANGE;
                gp_reg <= '0;
            end
            bpa_pkg::OP_ERR_NOBLK:
            begin
                st_reg <= bpa_pkg::ST_NOBLK;
                gp_reg <= '0;
            end
            bpa_pkg::OP_PUBLISH:
            begin
                out_st_reg <= st_reg;
                out_gp_reg <= gp_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_status = out_st_reg;
    assign res_page   = out_gp_reg;

endmodule

/* hdl/buddy_page_allocator_top.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator
// Per-order LIFO free lists with split on allocation and coalescing on free.
// ---------------------------------------------------------------------------
// - req carries one command per beat: allocate (block_order) or free
//   (block_order, page_number); rsp returns one beat per command.
// - cfg writes first_free_page and the pool is rebuilt. Write it only while
//   the block is idle. cfg.ready is always high.
// - After reset or a cfg write, a clearing pass over the page flags and a rebuild
//   of the pool run; req.ready stays low meanwhile.
// - One command is in flight at a time. An allocation scans up the orders for a
//   free block, then splits it down one order per step. A free coalesces with
//   its buddy one order per step, walking the buddy's list to unlink it.
// - A finished result sits in an output register; the next command is taken
//   while it waits. A stalled rsp holds the block before it can publish again.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_page_allocator_top (
    input  logic      clk,
    input  logic      rst_n,
    bpa_cfg_if.sink   cfg,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);

    bpa_pkg::dp_cmd_t  cmd;
    bpa_pkg::dp_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_data   (cfg.first_free_page),
        .in_cmd     (req.cmd),
        .in_order   (req.block_order),
        .in_page    (req.page_number),
        .stat       (stat),
        .res_status (rsp.status),
        .res_page   (rsp.granted_page)
    );

endmodule

/* hdl/bpa_checker.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator checker
// Port-level properties of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [bpa_pkg::STATUS_W-1:0] rsp_status,
    input logic [bpa_pkg::PAGE_W-1:0]   rsp_page,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);

    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NOW(a_status_code, rsp_valid, rsp_status != 2'd3)
    `ASSERT_NOW(a_err_page_zero, rsp_valid && rsp_status != bpa_pkg::ST_OK, rsp_page == '0)
    `ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready, !req_ready)
    `ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_page   (rsp.granted_page),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);

/* verif/buddy_page_allocator_top_tb.sv */
// ---------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free commands through the request channel, predicts each
// response with a behavioral copy of the free lists, and checks every beat on
// the response channel. The first-free-page register is rewritten between
// phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_page_allocator_top_tb;

    localparam int     EMPTY = bpa_pkg::NUM_PAGES;
    localparam longint LIMIT = 100000000;

    typedef struct packed {
        logic [bpa_pkg::STATUS_W-1:0] status;
        logic [bpa_pkg::PAGE_W-1:0]   page;
    } rsp_t;

    typedef struct {
        logic                         cmd;
        logic [bpa_pkg::ORDER_W-1:0]  ord;
        logic [bpa_pkg::PAGE_W-1:0]   page;
        logic                         known;
        logic [bpa_pkg::STATUS_W-1:0] st;
        logic [bpa_pkg::PAGE_W-1:0]   granted;
    } row_t;

    logic clk;
    logic rst_n;

    bpa_cfg_if cfg ();
    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow state of the allocator.
    bit        pg_free [bpa_pkg::NUM_PAGES];
    bit [3:0]  pg_ord [bpa_pkg::NUM_PAGES];
    int        link [bpa_pkg::NUM_PAGES];
    int        head [bpa_pkg::NUM_ORDERS];
    int        cnt [bpa_pkg::NUM_ORDERS];

    rsp_t      pending_rsp[$];
    int        live_blocks[$];      // page*16+order of blocks we hold
    int        errors;
    int        n_rsp;
    int        n_alloc_ok;
    int        n_free_ok;
    int        n_err;
    longint    cycles = 0;
    bit        hold_rsp;

    function automatic int clampl(int x);
        return (x < bpa_pkg::NUM_PAGES) ? x : EMPTY;
    endfunction

    function automatic void push_blk(int o, int p);
        link[p] = head[o];
        head[o] = p;
        pg_free[p] = 1'b1;
        pg_ord[p] = o[3:0];
        if (cnt[o] < 32767) cnt[o]++;
    endfunction

    function automatic int pop_blk(int o);
        int p;
        p = head[o];
        head[o] = clampl(link[p]);
        if (cnt[o] > 0) cnt[o]--;
        return p;
    endfunction

    function automatic void unlink_blk(int o, int b);
        int prv;
        int t;
        int steps;
        prv = EMPTY;
        t = head[o];
        steps = 0;
        while (t != EMPTY && steps < bpa_pkg::NUM_PAGES)
        begin
            if (t == b)
            begin
                if (prv == EMPTY) head[o] = clampl(link[t]);
                else link[prv] = clampl(link[t]);
                link[t] = EMPTY;
                if (cnt[o] > 0) cnt[o]--;
                return;
            end
            prv = t;
            t = clampl(link[t]);
            steps++;
        end
    endfunction

    function automatic void rebuild_pool(int first);
        int s;
        int rest;
        int o;
        for (int i = 0; i < bpa_pkg::NUM_PAGES; i++)
        begin
            pg_free[i] = 1'b0;
            pg_ord[i] = '0;
        end
        for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++)
        begin
            head[i] = EMPTY;
            cnt[i] = 0;
        end
        live_blocks.delete();
        s = (first + bpa_pkg::BLK_PAGES - 1) & ~(bpa_pkg::BLK_PAGES - 1);
        if (s >= bpa_pkg::NUM_PAGES) return;
        rest = bpa_pkg::NUM_PAGES - s;
        o = bpa_pkg::TOP_ORD;
        while (rest != 0)
        begin
            while (o > 0 && rest < (1 << o)) o--;
            push_blk(o, s);
            rest -= 1 << o;
            s += 1 << o;
        end
    endfunction

    function automatic rsp_t predict_rsp(logic c, int o, int page);
        rsp_t r;
        int i;
        int p;
        int pfn;
        int sz;
        int bud;
        r.status = bpa_pkg::ST_OK;
        r.page = '0;
        if (c == bpa_pkg::CMD_ALLOC)
        begin
            if (o >= bpa_pkg::NUM_ORDERS)
            begin
                r.status = bpa_pkg::ST_RANGE;
                return r;
            end
            i = o;
            while (i < bpa_pkg::NUM_ORDERS && head[i] == EMPTY) i++;
            if (i >= bpa_pkg::NUM_ORDERS)
            begin
                r.status = bpa_pkg::ST_NOBLK;
                return r;
            end
            while (i > o)
            begin
                p = pop_blk(i);
                i--;
                push_blk(i, p);
                push_blk(i, (p + (1 << i)) % bpa_pkg::NUM_PAGES);
            end
            p = pop_blk(o);
            pg_free[p] = 1'b0;
            link[p] = EMPTY;
            r.page = p[bpa_pkg::PAGE_W-1:0];
            live_blocks.push_back(p * 16 + o);
            return r;
        end
        if (o >= bpa_pkg::NUM_ORDERS || page >= bpa_pkg::NUM_PAGES
            || (page & ((1 << o) - 1)) != 0 || page + (1 << o) > bpa_pkg::NUM_PAGES)
        begin
            r.status = bpa_pkg::ST_RANGE;
            return r;
        end
        pfn = page;
        while (o < bpa_pkg::TOP_ORD)
        begin
            sz = 1 << o;
            bud = pfn ^ sz;
            if (bud + sz > bpa_pkg::NUM_PAGES) break;
            if (!pg_free[bud] || pg_ord[bud] != o) break;
            unlink_blk(o, bud);
            pg_free[bud] = 1'b0;
            pg_free[pfn] = 1'b0;
            if (bud < pfn) pfn = bud;
            o++;
        end
        push_blk(o, pfn);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: random stalls, plus a long hold-off when requested.
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp) rsp.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
                rsp.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            n_rsp++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected beat status=%0d page=%0d", $time,
                         rsp.status, rsp.granted_page);
                errors++;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp.status != exp_r.status)
                begin
                    $display("%0t status expected %0d actual %0d", $time,
                             exp_r.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_page != exp_r.page)
                begin
                    $display("%0t granted_page expected %0d actual %0d", $time,
                             exp_r.page, rsp.granted_page);
                    errors++;
                end
            end
        end
    end

    task automatic send_cmd(logic c, int o, int page, bit known, rsp_t want);
        rsp_t r;
        req.valid <= 1'b1;
        req.cmd <= c;
        req.block_order <= o[bpa_pkg::ORDER_W-1:0];
        req.page_number <= page[bpa_pkg::PAGE_W-1:0];
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        r = predict_rsp(c, o, page);
        if (known && r != want)
        begin
            $display("%0t table row expected st=%0d pg=%0d, predictor st=%0d pg=%0d",
                     $time, want.status, want.page, r.status, r.page);
            errors++;
        end
        pending_rsp.push_back(r);
        if (c == bpa_pkg::CMD_ALLOC && r.status == bpa_pkg::ST_OK) n_alloc_ok++;
        else if (r.status == bpa_pkg::ST_OK) n_free_ok++;
        else n_err++;
        // Random idle on the request side; back-to-back beats otherwise.
        if ($urandom_range(0, 2) == 0)
        begin
            req.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_first_free(int v);
        cfg.valid <= 1'b1;
        cfg.first_free_page <= v[bpa_pkg::CFG_W-1:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        rebuild_pool(v);
    endtask

    // Mostly allocate then free the blocks we hold, with some stray frees.
    task automatic random_phase(int n);
        int k;
        int o;
        int pg;
        int sel;
        rsp_t none;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 4);
                send_cmd(bpa_pkg::CMD_ALLOC, o, $urandom_range(0, 16383), 0, none);
            end
            else if (sel < 88 && live_blocks.size() != 0)
            begin
                k = $urandom_range(0, live_blocks.size() - 1);
                pg = live_blocks[k] / 16;
                o = live_blocks[k] % 16;
                live_blocks.delete(k);
                send_cmd(bpa_pkg::CMD_FREE, o, pg, 0, none);
            end
            else if (sel < 92 && live_blocks.size() != 0)
            begin
                // The block stays on the held list, so it can be freed again later.
                k = $urandom_range(0, live_blocks.size() - 1);
                send_cmd(bpa_pkg::CMD_FREE, live_blocks[k] % 16, live_blocks[k] / 16,
                         0, none);
            end
            else
            begin
                o = $urandom_range(0, 15);
                pg = $urandom_range(0, 16383);
                if ($urandom_range(0, 1) == 0 && o < bpa_pkg::NUM_ORDERS)
                    pg = pg & ~((1 << o) - 1);
                send_cmd(bpa_pkg::CMD_FREE, o, pg, 0, none);
            end
        end
    endtask

    row_t dir_rows[$];

    function automatic row_t mk(logic c, int o, int p, bit k, int st, int g);
        row_t r;
        r.cmd = c;
        r.ord = o[bpa_pkg::ORDER_W-1:0];
        r.page = p[bpa_pkg::PAGE_W-1:0];
        r.known = k;
        r.st = st[bpa_pkg::STATUS_W-1:0];
        r.granted = g[bpa_pkg::PAGE_W-1:0];
        return r;
    endfunction

    initial
    begin
        rsp_t want;
        rst_n = 1'b0;
        errors = 0;
        n_rsp = 0;
        n_alloc_ok = 0;
        n_free_ok = 0;
        n_err = 0;
        hold_rsp = 1'b0;
        req.valid = 1'b0;
        req.cmd = bpa_pkg::CMD_ALLOC;
        req.block_order = '0;
        req.page_number = '0;
        cfg.valid = 1'b0;
        cfg.first_free_page = '0;
        for (int i = 0; i < bpa_pkg::NUM_PAGES; i++) link[i] = 0;
        rebuild_pool(0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; fixed rows follow the pool layout after reset. The
        // upper half of every split is taken, so the first grants come from
        // the top of memory.
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 0, 1, bpa_pkg::ST_OK, 16383));
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 0, 16383, 1, bpa_pkg::ST_OK, 16382));
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 11, 0, 1, bpa_pkg::ST_RANGE, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 15, 0, 1, bpa_pkg::ST_RANGE, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 11, 0, 1, bpa_pkg::ST_RANGE, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 3, 5, 1, bpa_pkg::ST_RANGE, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 10, 16383, 1, bpa_pkg::ST_RANGE, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 0, 16382, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 0, 16383, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 10, 0, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_ALLOC, 5, 0, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 5, 15360, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 5, 15360, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 0, 16383, 0, 0, 0));
        dir_rows.push_back(mk(bpa_pkg::CMD_FREE, 10, 15360, 0, 0, 0));
        foreach (dir_rows[i])
        begin
            want.status = dir_rows[i].st;
            want.page = dir_rows[i].granted;
            send_cmd(dir_rows[i].cmd, dir_rows[i].ord, dir_rows[i].page,
                     dir_rows[i].known, want);
        end
        drain();

        // A first-free-page of 16384 leaves an empty pool: every allocation fails.
        write_first_free(16384);
        send_cmd(bpa_pkg::CMD_ALLOC, 0, 0, 1, '{bpa_pkg::ST_NOBLK, 14'd0});
        send_cmd(bpa_pkg::CMD_FREE, 0, 16383, 0, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, 1, 0, 0, '0);
        drain();

        write_first_free(15361);
        random_phase(150);
        drain();

        write_first_free(32767);
        random_phase(60);
        drain();

        write_first_free(13000);
        // Hold the response side long enough for the request side to stall.
        fork
            begin
                hold_rsp = 1'b1;
                repeat (3000) @(posedge clk);
                hold_rsp = 1'b0;
            end
            random_phase(40);
        join
        random_phase(500);
        drain();

        write_first_free(0);
        random_phase(700);
        drain();

        $display("Run covered %0d responses: %0d grants, %0d frees, %0d errors,",
                 n_rsp, n_alloc_ok, n_free_ok, n_err);
        $display("over six pool settings including empty and fully reserved pools.");
        if (errors == 0 && pending_rsp.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
